// ----- hw/rtl/chebyshev_series_eval_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Chebyshev series core checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_SERIES_EVAL_CORE_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVAL_CORE_ASSERT_SVH

// same-cycle implication
`define CHEBSE_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chebse: same-cycle property violated");

// next-cycle implication
`define CHEBSE_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chebse: next-cycle property violated");

`endif

// ----- hw/rtl/chebse_pkg.sv -----
// ----------------------------------------------------------------------------
// chebse_pkg
// Widths, register codes, types and helpers shared by the Chebyshev core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chebse_pkg;

	localparam int MAX_DEGREE = 5;
	localparam int NUM_COEF   = MAX_DEGREE + 1;

	localparam int X_W      = 16;   // Q1.14 sample
	localparam int COEF_W   = 16;   // Q3.12 coefficient
	localparam int DEG_W    = 3;
	localparam int Y_W      = 19;   // result, 12 fraction bits
	localparam int D_W      = 21;   // power-basis weight
	localparam int FRAC_X   = 14;
	localparam int OUT_SHIFT = FRAC_X * MAX_DEGREE;
	localparam int ACC_W    = 98;   // exact Horner accumulator
	localparam int LO_W     = 32;   // low chunks of the accumulator
	localparam int HI_W     = ACC_W - 2 * LO_W;
	localparam int PL_W     = LO_W + 1 + X_W;
	localparam int PH_W     = HI_W + X_W;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF0  = 3'd1;

	// half an output step, added once before the final truncation
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		{{(ACC_W - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};

	typedef logic [NUM_COEF-1:0][D_W-1:0] chebse_wts_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [X_W-1:0]   x;
	} chebse_lane_t;

	// weight placed at its power-of-2^14 position
	function automatic logic signed [ACC_W-1:0] term_of(input logic [D_W-1:0] d,
			input int unsigned steps);
		logic signed [ACC_W-1:0] ext;
		begin
			ext = ACC_W'($signed(d));
			return ext <<< (FRAC_X * steps);
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chebse_cfg.sv -----
// ----------------------------------------------------------------------------
// chebse_cfg
// APB register file; folds Chebyshev weights into power-basis weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chebse_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [chebse_pkg::PADDR_W-1:0]    paddr,
	input  logic [chebse_pkg::PDATA_W-1:0]    pwdata,
	output logic [chebse_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready,
	output chebse_pkg::chebse_wts_t           wts
);

	logic [chebse_pkg::DEG_W-1:0]         degree_q;
	logic signed [chebse_pkg::COEF_W-1:0] coef_q [chebse_pkg::NUM_COEF];
	chebse_pkg::chebse_wts_t              d_q;
	chebse_pkg::chebse_wts_t              d_c;
	logic [chebse_pkg::REG_IDX_W-1:0]     idx;
	logic                                 wr;
	logic [chebse_pkg::DEG_W-1:0]         deg_eff;
	logic signed [chebse_pkg::D_W-1:0]    c [chebse_pkg::NUM_COEF];

	assign pready = 1'b1;
	assign idx    = paddr[chebse_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int k = 0; k < chebse_pkg::NUM_COEF; k++) begin
				coef_q[k] <= '0;
			end
		end else if (wr) begin
			if (idx == chebse_pkg::REG_DEGREE) begin
				degree_q <= pwdata[chebse_pkg::DEG_W-1:0];
			end
			for (int k = 0; k < chebse_pkg::NUM_COEF; k++) begin
				if (idx == chebse_pkg::REG_IDX_W'(int'(chebse_pkg::REG_COEF0) + k)) begin
					coef_q[k] <= $signed(pwdata[chebse_pkg::COEF_W-1:0]);
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == chebse_pkg::REG_DEGREE) begin
			prdata = chebse_pkg::PDATA_W'(degree_q);
		end
		for (int k = 0; k < chebse_pkg::NUM_COEF; k++) begin
			if (idx == chebse_pkg::REG_IDX_W'(int'(chebse_pkg::REG_COEF0) + k)) begin
				prdata = {{(chebse_pkg::PDATA_W - chebse_pkg::COEF_W){1'b0}}, coef_q[k]};
			end
		end
	end

	// degree codes above the top term act as the top term
	assign deg_eff = (degree_q > chebse_pkg::DEG_W'(chebse_pkg::MAX_DEGREE)) ?
		chebse_pkg::DEG_W'(chebse_pkg::MAX_DEGREE) : degree_q;

	always_comb begin
		for (int k = 0; k < chebse_pkg::NUM_COEF; k++) begin
			c[k] = (chebse_pkg::DEG_W'(k) <= deg_eff) ? chebse_pkg::D_W'(coef_q[k]) : '0;
		end
		d_c[0] = c[0] - c[2] + c[4];
		d_c[1] = c[1] - (c[3] + (c[3] <<< 1)) + (c[5] + (c[5] <<< 2));
		d_c[2] = (c[2] <<< 1) - (c[4] <<< 3);
		d_c[3] = (c[3] <<< 2) - ((c[5] <<< 4) + (c[5] <<< 2));
		d_c[4] = c[4] <<< 3;
		d_c[5] = c[5] <<< 4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else begin
			d_q <= d_c;
		end
	end

	assign wts = d_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chebse_step.sv -----
// ----------------------------------------------------------------------------
// chebse_step
// One Horner step: acc * x + term, as a multiply stage and a sum stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chebse_step (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  chebse_pkg::chebse_lane_t               up_lane,
	input  logic signed [chebse_pkg::ACC_W-1:0]    term,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output chebse_pkg::chebse_lane_t               dn_lane
);

	logic                                  v_s1;
	logic                                  v_s2;
	logic                                  en_s1;
	logic                                  en_s2;
	logic signed [chebse_pkg::LO_W:0]      a0;
	logic signed [chebse_pkg::LO_W:0]      a1;
	logic signed [chebse_pkg::HI_W-1:0]    a2;
	logic signed [chebse_pkg::PL_W-1:0]    p0_d;
	logic signed [chebse_pkg::PL_W-1:0]    p1_d;
	logic signed [chebse_pkg::PH_W-1:0]    p2_d;
	logic signed [chebse_pkg::PL_W-1:0]    p0_s1;
	logic signed [chebse_pkg::PL_W-1:0]    p1_s1;
	logic signed [chebse_pkg::PH_W-1:0]    p2_s1;
	logic signed [chebse_pkg::X_W-1:0]     x_s1;
	logic signed [chebse_pkg::ACC_W-1:0]   sum_d;
	chebse_pkg::chebse_lane_t              lane_s2;

	assign en_s2    = !v_s2 || dn_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	// two unsigned low chunks, signed top chunk
	assign a0 = $signed({1'b0, up_lane.acc[chebse_pkg::LO_W-1:0]});
	assign a1 = $signed({1'b0, up_lane.acc[2*chebse_pkg::LO_W-1:chebse_pkg::LO_W]});
	assign a2 = up_lane.acc[chebse_pkg::ACC_W-1:2*chebse_pkg::LO_W];

	assign p0_d = chebse_pkg::PL_W'(a0) * chebse_pkg::PL_W'(up_lane.x);
	assign p1_d = chebse_pkg::PL_W'(a1) * chebse_pkg::PL_W'(up_lane.x);
	assign p2_d = chebse_pkg::PH_W'(a2) * chebse_pkg::PH_W'(up_lane.x);

	assign sum_d = chebse_pkg::ACC_W'(p0_s1)
		+ (chebse_pkg::ACC_W'(p1_s1) <<< chebse_pkg::LO_W)
		+ (chebse_pkg::ACC_W'(p2_s1) <<< (2 * chebse_pkg::LO_W))
		+ term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= up_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			p0_s1 <= p0_d;
			p1_s1 <= p1_d;
			p2_s1 <= p2_d;
			x_s1  <= up_lane.x;
		end
		if (en_s2 && v_s1) begin
			lane_s2.acc <= sum_d;
			lane_s2.x   <= x_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_lane  = lane_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/chebyshev_series_eval_core.sv -----
// ----------------------------------------------------------------------------
// chebyshev_series_eval_core
// Evaluates p(x) = sum of coef_k * T_k(x), k up to the set degree (max 5).
//
//   Channel | Dir | Signals                         | Item
//   s_      | in  | s_tvalid s_tready s_tdata[15:0] | x_value, Q1.14 signed
//   m_      | out | m_tvalid m_tready m_tdata[23:0] | y_value, 19b signed, 12 frac
//   apb     | in  | psel penable pwrite paddr pwdata| degree, coef_0..coef_5
//
// One item per clock sustained while m_tready is high.
// The input register loads at the accept edge; then come the five Horner
// steps, each a multiply stage and a sum stage.
// arst_n clears all valid bits and the register file (degree 0, coefs 0).
// Backpressure ripples upstream stage by stage; empty stages keep filling,
// so s_tready stays high while any bubble remains in the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_series_eval_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [chebse_pkg::S_DATA_W-1:0]   s_tdata,   // [15:0] x_value
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [chebse_pkg::M_DATA_W-1:0]   m_tdata,   // [18:0] y_value, [23:19] zero
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [chebse_pkg::PADDR_W-1:0]    paddr,
	input  logic [chebse_pkg::PDATA_W-1:0]    pwdata,
	output logic [chebse_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready
);

	chebse_pkg::chebse_wts_t                wts;
	logic                                   v_s1;
	logic signed [chebse_pkg::X_W-1:0]      x_s1;
	logic [chebse_pkg::MAX_DEGREE:0]        vld;
	logic [chebse_pkg::MAX_DEGREE:0]        rdy;
	chebse_pkg::chebse_lane_t               lane [chebse_pkg::MAX_DEGREE+1];
	logic signed [chebse_pkg::ACC_W-1:0]    term [chebse_pkg::MAX_DEGREE];

	// Register file. The power-basis weights d0..d5 are folded from the Chebyshev
	// coefficients, registered; user must only change them while idle (not enforced).
	chebse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.wts     (wts)
	);

	// Input register: s_tready is high when it is empty or the first step is ready.
	assign s_tready = !v_s1 || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1 <= $signed(s_tdata);
		end
	end

	// Horner seed is d5; the accumulator stays exact all the way down
	// (|S| < 2^96), so nothing is rounded until the output bit slice.
	assign vld[0]  = v_s1;
	assign lane[0] = '{acc: chebse_pkg::ACC_W'($signed(wts[chebse_pkg::MAX_DEGREE])),
		x: x_s1};

	// Step k adds d_j at weight 2^(14*(k+1)), j counting down from 4.
	// The last step also carries the rounding half: d0 sits at bit 70 and
	// up, so the half at bit 69 can be OR-ed in.
	for (genvar k = 0; k < chebse_pkg::MAX_DEGREE; k++) begin : g_step
		if (k == chebse_pkg::MAX_DEGREE - 1) begin : g_last
			assign term[k] = chebse_pkg::term_of(wts[chebse_pkg::MAX_DEGREE-1-k], k + 1)
				| chebse_pkg::ROUND_HALF;
		end else begin : g_mid
			assign term[k] = chebse_pkg::term_of(wts[chebse_pkg::MAX_DEGREE-1-k], k + 1);
		end

		chebse_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up_lane  (lane[k]),
			.term     (term[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_lane  (lane[k+1])
		);
	end

	// Output: the last sum register drives m_ directly; y is bits [88:70]
	// of the rounded accumulator, wrapping if out of range.
	assign rdy[chebse_pkg::MAX_DEGREE] = m_tready;
	assign m_tvalid = vld[chebse_pkg::MAX_DEGREE];
	assign m_tdata  = {{(chebse_pkg::M_DATA_W - chebse_pkg::Y_W){1'b0}},
		lane[chebse_pkg::MAX_DEGREE].acc[chebse_pkg::OUT_SHIFT+chebse_pkg::Y_W-1:
			chebse_pkg::OUT_SHIFT]};

endmodule

`default_nettype wire

// ----- hw/rtl/chebse_checker.sv -----
// ----------------------------------------------------------------------------
// chebse_checker
// Port-level properties of the Chebyshev series core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chebyshev_series_eval_core_assert.svh"

module chebse_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [chebse_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [chebse_pkg::PADDR_W-1:0]    paddr,
	input logic [chebse_pkg::PDATA_W-1:0]    pwdata,
	input logic [chebse_pkg::PDATA_W-1:0]    prdata,
	input logic                              pready
);

	logic                           deg_wr;
	logic                           deg_rd;
	logic                           in_acc;
	logic                           pad_zero;
	logic [chebse_pkg::DEG_W-1:0]   wr_deg;
	logic [chebse_pkg::DEG_W-1:0]   rd_deg;

	assign deg_wr = psel && penable && pwrite && pready
		&& (paddr[chebse_pkg::PADDR_W-1:2] == chebse_pkg::REG_DEGREE);
	assign deg_rd = psel && !pwrite
		&& (paddr[chebse_pkg::PADDR_W-1:2] == chebse_pkg::REG_DEGREE);
	assign in_acc = s_tvalid && s_tready;
	assign pad_zero = (m_tdata[chebse_pkg::M_DATA_W-1:chebse_pkg::Y_W] == '0);
	assign wr_deg = pwdata[chebse_pkg::DEG_W-1:0];
	assign rd_deg = prdata[chebse_pkg::DEG_W-1:0];

	// the pipe only refuses input when it is full behind a stalled output
	`CHEBSE_AST_IMP(a_full_only_when_stalled, !s_tready, m_tvalid && !m_tready)

	// pad bits above y_value stay zero
	`CHEBSE_AST_IMP(a_pad_zero, m_tvalid || in_acc, pad_zero)

	// a stalled result holds
	`CHEBSE_AST_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// degree reads back what was just written
	`CHEBSE_AST_NXT(a_deg_readback, deg_wr, !deg_rd || (rd_deg == $past(wr_deg)))

endmodule

bind chebyshev_series_eval_core chebse_checker u_chebse_checker (.*);

`default_nettype wire
